@@ src/ffca_pkg.sv @@
// Shared types and codes for the first-fit coalescing allocator.
package ffca_pkg;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_NOMEM = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    localparam logic REG_REGION_SIZE = 1'b0;
    localparam logic REG_ALIGN_LOG2  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] req_offset;
        logic [31:0] req_size;
    } req_t;

    typedef struct packed {
        logic [31:0] alloc_offset;
        logic [1:0]  status;
    } rsp_t;

    typedef struct packed {
        logic [31:0] region_size;
        logic [4:0]  align_log2;
        logic        reinit;
    } cfg_t;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SCAN = 8'b0000_0010,
        S_SHDN = 8'b0000_0100,
        S_SHUP = 8'b0000_1000,
        S_MRG1 = 8'b0001_0000,
        S_MRG2 = 8'b0010_0000,
        S_PUT  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } state_t;

endpackage

@@ src/ffca_mem.sv @@
// Free-list memory: one write port, one registered read port.
module ffca_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/ffca_cfg.sv @@
// Configuration registers behind the APB-style port.
module ffca_cfg #(
    parameter int ADDR_BITS = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output ffca_pkg::cfg_t cfg
);

    localparam logic [31:0] LIM = (ADDR_BITS >= 32) ? 32'hFFFF_FFFF :
                                  32'((64'd1 << ADDR_BITS) - 64'd1);

    logic [31:0] region_reg;
    logic [31:0] region_next;
    logic [4:0]  align_reg;
    logic [4:0]  align_next;
    logic        wr;

    assign wr = psel && penable && pwrite;

    always_comb
    begin
        region_next = region_reg;
        align_next  = align_reg;
        if (wr && paddr[2] == ffca_pkg::REG_REGION_SIZE)
        begin
            region_next = (pwdata > LIM) ? LIM : pwdata;
        end
        if (wr && paddr[2] == ffca_pkg::REG_ALIGN_LOG2)
        begin
            align_next = pwdata[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg <= (32'd16777216 > LIM) ? LIM : 32'd16777216;
            align_reg  <= 5'd12;
        end
        else
        begin
            region_reg <= region_next;
            align_reg  <= align_next;
        end
    end

    assign prdata = (paddr[2] == ffca_pkg::REG_REGION_SIZE) ? region_reg :
                    {27'd0, align_reg};
    assign pready = 1'b1;

    assign cfg.region_size = region_reg;
    assign cfg.align_log2  = align_reg;
    assign cfg.reinit      = wr && paddr[2] == ffca_pkg::REG_REGION_SIZE;

endmodule

@@ src/first_fit_coalescing_allocator.sv @@
// First-fit free-list allocator with coalescing: control sequencer and top level.
// Free blocks live in one memory, one entry per cycle through its single read port.
// An allocate reads entries through the first fit (the whole list when none fits) and,
// on an exact fit that is not the last entry, shifts the later entries down. A free
// reads entries through the first one at or past the offset (the whole list when there
// is none), then shifts entries up on a plain insert before the end, or shifts them
// down on a double merge that is not at the end. Status-only requests skip the scan.
// Any of these waits while the output register still holds a beat that has not been
// taken. One request is in work at a time; a result waits in the output register
// while the next is taken.
module first_fit_coalescing_allocator #(
    parameter int MAX_BLOCKS = 64,
    parameter int ADDR_BITS  = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_stall,
    input  ffca_pkg::req_t        req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output ffca_pkg::rsp_t        rsp_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int AW = ADDR_BITS;
    localparam int EW = 2 * AW;
    localparam int WW = ((AW > 32) ? AW : 32) + 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam logic [WW-1:0] MASK_W = WW'({AW{1'b1}});
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_BLOCKS);

    ffca_pkg::cfg_t   cfg;
    ffca_pkg::state_t state_reg, state_next;

    logic          act_reg, act_next;
    logic [31:0]   off_reg, off_next;
    logic [AW-1:0] rnd_reg, rnd_next;
    logic [1:0]    st_reg, st_next;
    logic [AW-1:0] res_reg, res_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] wp_reg, wp_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic          dv_reg, dv_next;
    logic          lv_reg, lv_next;
    logic          rv_reg, rv_next;
    logic          rm_reg, rm_next;
    logic [AW-1:0] nl_reg, nl_next;
    logic [EW-1:0] l_reg, l_next;
    logic [EW-1:0] r_reg, r_next;
    logic          fresh_reg, fresh_next;
    logic          rdf_reg;
    logic          rsp_valid_reg, rsp_valid_next;
    ffca_pkg::rsp_t rsp_reg, rsp_next;

    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [IW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    logic [WW-1:0] amask_w;
    logic [WW-1:0] rnd_w;
    logic [WW-1:0] region_w;
    logic [AW-1:0] region_a;
    logic [AW-1:0] off_a;
    logic [EW-1:0] ent;
    logic [AW-1:0] ent_start;
    logic [AW-1:0] ent_len;
    logic [CW-1:0] chk;
    logic          last;
    logic [WW-1:0] rsum_w;
    logic [WW-1:0] rend_w;
    logic [WW-1:0] lend_w;
    logic [WW-1:0] lsum_w;
    logic [AW-1:0] lsum;
    logic [WW-1:0] astart_w;

    ffca_cfg #(
        .ADDR_BITS(ADDR_BITS)
    ) u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready),
        .cfg    (cfg)
    );

    ffca_mem #(
        .DEPTH(MAX_BLOCKS),
        .WIDTH(EW)
    ) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    assign region_w  = WW'(cfg.region_size);
    assign region_a  = region_w[AW-1:0];
    assign off_a     = AW'(off_reg);
    assign amask_w   = (WW'(1) << cfg.align_log2) - WW'(1);
    assign rnd_w     = (WW'(req_data.req_size) + amask_w) & ~amask_w;
    assign ent       = rdf_reg ? {{AW{1'b0}}, region_a} : mem_rdata;
    assign ent_start = ent[EW-1:AW];
    assign ent_len   = ent[AW-1:0];
    assign chk       = idx_reg - CW'(1);
    assign last      = idx_reg == cnt_reg;
    assign astart_w  = WW'(ent_start) + WW'(rnd_reg);
    assign rend_w    = (WW'(off_a) + WW'(rnd_reg)) & MASK_W;
    assign rsum_w    = WW'(rnd_reg) + WW'(r_reg[AW-1:0]);
    assign lend_w    = (WW'(l_reg[EW-1:AW]) + WW'(l_reg[AW-1:0])) & MASK_W;
    assign lsum_w    = WW'(l_reg[AW-1:0]) + WW'(nl_reg);
    assign lsum      = (lsum_w > MASK_W) ? {AW{1'b1}} : lsum_w[AW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        act_next       = act_reg;
        off_next       = off_reg;
        rnd_next       = rnd_reg;
        st_next        = st_reg;
        res_next       = res_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        wp_next        = wp_reg;
        pos_next       = pos_reg;
        dv_next        = dv_reg;
        lv_next        = lv_reg;
        rv_next        = rv_reg;
        rm_next        = rm_reg;
        nl_next        = nl_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = pos_reg[IW-1:0];
        mem_wdata      = {off_a, rnd_reg};
        mem_raddr      = idx_reg[IW-1:0];

        case (state_reg)
            ffca_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next = req_data.action;
                    off_next = req_data.req_offset;
                    rnd_next = rnd_w[AW-1:0];
                    res_next = '0;
                    st_next  = ffca_pkg::ST_OK;
                    idx_next = '0;
                    dv_next  = 1'b0;
                    lv_next  = 1'b0;
                    rv_next  = 1'b0;
                    pos_next = '0;
                    if (req_data.action == ffca_pkg::ACT_ALLOC)
                    begin
                        if (req_data.req_size == 32'd0 || rnd_w > MASK_W)
                        begin
                            st_next    = ffca_pkg::ST_INVAL;
                            state_next = ffca_pkg::S_DONE;
                        end
                        else if (cnt_reg == '0)
                        begin
                            st_next    = ffca_pkg::ST_NOMEM;
                            state_next = ffca_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = ffca_pkg::S_SCAN;
                        end
                    end
                    else
                    begin
                        if (req_data.req_size == 32'd0)
                        begin
                            state_next = ffca_pkg::S_DONE;
                        end
                        else if (WW'(req_data.req_offset) >= region_w || rnd_w > MASK_W)
                        begin
                            st_next    = ffca_pkg::ST_INVAL;
                            state_next = ffca_pkg::S_DONE;
                        end
                        else if (cnt_reg >= MAX_C)
                        begin
                            st_next    = ffca_pkg::ST_FULL;
                            state_next = ffca_pkg::S_DONE;
                        end
                        else if (cnt_reg == '0)
                        begin
                            state_next = ffca_pkg::S_MRG1;
                        end
                        else
                        begin
                            state_next = ffca_pkg::S_SCAN;
                        end
                    end
                end
            end

            ffca_pkg::S_SCAN:
            begin
                idx_next = idx_reg + CW'(1);
                dv_next  = 1'b1;
                if (dv_reg)
                begin
                    if (act_reg == ffca_pkg::ACT_ALLOC)
                    begin
                        if (ent_len >= rnd_reg)
                        begin
                            res_next = ent_start;
                            if (ent_len == rnd_reg)
                            begin
                                if (last)
                                begin
                                    cnt_next   = cnt_reg - CW'(1);
                                    state_next = ffca_pkg::S_DONE;
                                end
                                else
                                begin
                                    wp_next    = chk;
                                    idx_next   = idx_reg;
                                    dv_next    = 1'b0;
                                    state_next = ffca_pkg::S_SHDN;
                                end
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = chk[IW-1:0];
                                mem_wdata  = {astart_w[AW-1:0], ent_len - rnd_reg};
                                state_next = ffca_pkg::S_DONE;
                            end
                        end
                        else if (last)
                        begin
                            st_next    = ffca_pkg::ST_NOMEM;
                            state_next = ffca_pkg::S_DONE;
                        end
                    end
                    else
                    begin
                        if (WW'(ent_start) >= WW'(off_a))
                        begin
                            pos_next   = chk;
                            r_next     = ent;
                            rv_next    = 1'b1;
                            state_next = ffca_pkg::S_MRG1;
                        end
                        else
                        begin
                            l_next  = ent;
                            lv_next = 1'b1;
                            if (last)
                            begin
                                pos_next   = cnt_reg;
                                state_next = ffca_pkg::S_MRG1;
                            end
                        end
                    end
                end
            end

            ffca_pkg::S_MRG1:
            begin
                rm_next = rv_reg && rend_w == WW'(r_reg[EW-1:AW]);
                nl_next = rnd_reg;
                if (rv_reg && rend_w == WW'(r_reg[EW-1:AW]))
                begin
                    nl_next = (rsum_w > MASK_W) ? {AW{1'b1}} : rsum_w[AW-1:0];
                end
                state_next = ffca_pkg::S_MRG2;
            end

            ffca_pkg::S_MRG2:
            begin
                if (lv_reg && lend_w == WW'(off_a))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = IW'(pos_reg - CW'(1));
                    mem_wdata = {l_reg[EW-1:AW], lsum};
                    if (rm_reg)
                    begin
                        if (pos_reg == cnt_reg - CW'(1))
                        begin
                            cnt_next   = cnt_reg - CW'(1);
                            state_next = ffca_pkg::S_DONE;
                        end
                        else
                        begin
                            wp_next    = pos_reg;
                            idx_next   = pos_reg + CW'(1);
                            dv_next    = 1'b0;
                            state_next = ffca_pkg::S_SHDN;
                        end
                    end
                    else
                    begin
                        state_next = ffca_pkg::S_DONE;
                    end
                end
                else if (rm_reg)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = {off_a, nl_reg};
                    state_next = ffca_pkg::S_DONE;
                end
                else if (pos_reg == cnt_reg)
                begin
                    mem_we     = 1'b1;
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = ffca_pkg::S_DONE;
                end
                else
                begin
                    idx_next   = cnt_reg - CW'(1);
                    wp_next    = cnt_reg;
                    dv_next    = 1'b0;
                    state_next = ffca_pkg::S_SHUP;
                end
            end

            ffca_pkg::S_SHDN:
            begin
                dv_next = 1'b1;
                if (idx_reg < cnt_reg)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (dv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wp_reg[IW-1:0];
                    mem_wdata = ent;
                    wp_next   = wp_reg + CW'(1);
                    if (wp_reg == cnt_reg - CW'(2))
                    begin
                        cnt_next   = cnt_reg - CW'(1);
                        state_next = ffca_pkg::S_DONE;
                    end
                end
            end

            ffca_pkg::S_SHUP:
            begin
                dv_next = 1'b1;
                if (idx_reg != pos_reg)
                begin
                    idx_next = idx_reg - CW'(1);
                end
                if (dv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wp_reg[IW-1:0];
                    mem_wdata = ent;
                    wp_next   = wp_reg - CW'(1);
                    if (wp_reg == pos_reg + CW'(1))
                    begin
                        state_next = ffca_pkg::S_PUT;
                    end
                end
            end

            ffca_pkg::S_PUT:
            begin
                mem_we     = 1'b1;
                cnt_next   = cnt_reg + CW'(1);
                state_next = ffca_pkg::S_DONE;
            end

            ffca_pkg::S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next        = 1'b1;
                    rsp_next.status       = st_reg;
                    rsp_next.alloc_offset = (st_reg == ffca_pkg::ST_OK) ?
                                            32'(WW'(res_reg)) : 32'd0;
                    state_next            = ffca_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ffca_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fresh_next = fresh_reg;
        if (mem_we && mem_waddr == '0)
        begin
            fresh_next = 1'b0;
        end
        if (cfg.reinit)
        begin
            fresh_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffca_pkg::S_IDLE;
            cnt_reg       <= CW'(1);
            fresh_reg     <= 1'b1;
            rdf_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
            dv_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cfg.reinit ? CW'(1) : cnt_next;
            fresh_reg     <= fresh_next;
            rdf_reg       <= fresh_reg && mem_raddr == '0;
            rsp_valid_reg <= rsp_valid_next;
            dv_reg        <= dv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        off_reg <= off_next;
        rnd_reg <= rnd_next;
        st_reg  <= st_next;
        res_reg <= res_next;
        idx_reg <= idx_next;
        wp_reg  <= wp_next;
        pos_reg <= pos_next;
        lv_reg  <= lv_next;
        rv_reg  <= rv_next;
        rm_reg  <= rm_next;
        nl_reg  <= nl_next;
        l_reg   <= l_next;
        r_reg   <= r_next;
        rsp_reg <= rsp_next;
    end

    assign req_stall = state_reg != ffca_pkg::S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= MAX_C)
        else $error("free list count beyond capacity");

    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ffca_pkg::S_DONE))
        else $error("result beat without a finished request");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg != ffca_pkg::S_IDLE)
        else $error("list write while idle");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the first-fit coalescing allocator.
`timescale 1ns / 1ps

module tb_top;

    localparam int NBLK = 64;
    localparam logic [63:0] AMASK = 64'h0000_0000_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 2000000;

    class alloc_scoreboard;
        logic [63:0] blk_start[NBLK];
        logic [63:0] blk_len[NBLK];
        int unsigned blk_count;
        logic [63:0] region;
        int unsigned align;
        ffca_pkg::rsp_t pending[$];
        int errors;

        function void rebuild();
            for (int i = 0; i < NBLK; i++)
            begin
                blk_start[i] = 64'd0;
                blk_len[i] = 64'd0;
            end
            blk_len[0] = region;
            blk_count = 1;
        endfunction

        function void reset_state();
            region = 64'd16777216;
            align = 12;
            errors = 0;
            pending.delete();
            rebuild();
        endfunction

        function void configure(logic idx, logic [31:0] value);
            if (idx == ffca_pkg::REG_REGION_SIZE)
            begin
                region = {32'd0, value};
                rebuild();
            end
            else
                align = 32'(value[4:0]);
        endfunction

        function void drop_entry(int unsigned idx);
            for (int unsigned i = idx; i + 1 < blk_count; i++)
            begin
                blk_start[i] = blk_start[i + 1];
                blk_len[i] = blk_len[i + 1];
            end
            blk_count--;
            blk_start[blk_count] = 64'd0;
            blk_len[blk_count] = 64'd0;
        endfunction

        function bit adjacent(int unsigned l, int unsigned r);
            return ((blk_start[l] + blk_len[l]) & AMASK) == blk_start[r];
        endfunction

        function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
            logic [63:0] s;
            s = a + b;
            return (s > AMASK) ? AMASK : s;
        endfunction

        function ffca_pkg::rsp_t note(ffca_pkg::req_t r);
            logic [63:0] mask;
            logic [63:0] rounded;
            logic [63:0] offs;
            logic [63:0] sz;
            logic [1:0] st;
            logic [63:0] res;
            int unsigned pos;
            ffca_pkg::rsp_t e;
            mask = (64'd1 << align) - 64'd1;
            offs = {32'd0, r.req_offset};
            sz = {32'd0, r.req_size};
            rounded = (sz + mask) & ~mask;
            st = ffca_pkg::ST_OK;
            res = 64'd0;
            if (r.action == ffca_pkg::ACT_ALLOC)
            begin
                if (sz == 64'd0 || rounded > AMASK)
                    st = ffca_pkg::ST_INVAL;
                else
                begin
                    st = ffca_pkg::ST_NOMEM;
                    for (int unsigned i = 0; i < blk_count; i++)
                    begin
                        if (blk_len[i] >= rounded)
                        begin
                            res = blk_start[i];
                            if (blk_len[i] == rounded)
                                drop_entry(i);
                            else
                            begin
                                blk_start[i] = (blk_start[i] + rounded) & AMASK;
                                blk_len[i] = blk_len[i] - rounded;
                            end
                            st = ffca_pkg::ST_OK;
                            break;
                        end
                    end
                end
            end
            else if (sz != 64'd0)
            begin
                if (offs >= region || rounded > AMASK)
                    st = ffca_pkg::ST_INVAL;
                else if (blk_count >= NBLK)
                    st = ffca_pkg::ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < blk_count && blk_start[pos] < offs)
                        pos++;
                    for (int unsigned i = blk_count; i > pos; i--)
                    begin
                        blk_start[i] = blk_start[i - 1];
                        blk_len[i] = blk_len[i - 1];
                    end
                    blk_start[pos] = offs;
                    blk_len[pos] = rounded;
                    blk_count++;
                    if (pos + 1 < blk_count && adjacent(pos, pos + 1))
                    begin
                        blk_len[pos] = sat_sum(blk_len[pos], blk_len[pos + 1]);
                        drop_entry(pos + 1);
                    end
                    if (pos > 0 && adjacent(pos - 1, pos))
                    begin
                        blk_len[pos - 1] = sat_sum(blk_len[pos - 1], blk_len[pos]);
                        drop_entry(pos);
                    end
                end
            end
            e.alloc_offset = (st == ffca_pkg::ST_OK) ? res[31:0] : 32'd0;
            e.status = st;
            pending = {pending, e};
            return e;
        endfunction

        function void check(ffca_pkg::rsp_t got);
            ffca_pkg::rsp_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected beat: alloc_offset %h status %0d",
                       got.alloc_offset, got.status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.alloc_offset !== e.alloc_offset)
            begin
                $error("alloc_offset: expected %h actual %h", e.alloc_offset, got.alloc_offset);
                errors++;
            end
            if (got.status !== e.status)
            begin
                $error("status: expected %0d actual %0d", e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    ffca_pkg::req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    ffca_pkg::rsp_t rsp_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    alloc_scoreboard sb;
    bit quiet;
    longint cycles;
    logic [31:0] live_off[$];
    logic [31:0] live_size[$];
    logic [31:0] unit;

    first_fit_coalescing_allocator dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_data(req_data),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp_data(rsp_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check(rsp_data);
    end

    initial
    begin
        int n;
        rsp_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            n = quiet ? 0 : $urandom_range(0, 17);
            if (n > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            do @(posedge clk); while (!rsp_valid);
        end
    end

    task automatic send(input ffca_pkg::req_t r, output ffca_pkg::rsp_t e);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data <= r;
        do @(posedge clk); while (req_stall);
        e = sb.note(r);
    endtask

    task automatic issue(input logic act, input logic [31:0] offs, input logic [31:0] sz);
        ffca_pkg::req_t r;
        ffca_pkg::rsp_t e;
        r.action = act;
        r.req_offset = offs;
        r.req_size = sz;
        send(r, e);
        if (act == ffca_pkg::ACT_ALLOC && e.status == ffca_pkg::ST_OK)
        begin
            live_off = {live_off, e.alloc_offset};
            live_size = {live_size, sz};
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic reg_write(input logic idx, input logic [31:0] value);
        drain();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.configure(idx, value);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == ffca_pkg::REG_REGION_SIZE)
        begin
            live_off.delete();
            live_size.delete();
        end
    endtask

    task automatic mixed(input int count);
        int k;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50 || live_off.size() == 0)
                issue(ffca_pkg::ACT_ALLOC, $urandom, $urandom_range(1, unit));
            else if (pick < 85)
            begin
                k = $urandom_range(0, live_off.size() - 1);
                issue(ffca_pkg::ACT_FREE, live_off[k], live_size[k]);
                live_off.delete(k);
                live_size.delete(k);
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: issue(1'($urandom_range(0, 1)), $urandom, $urandom);
                    1: issue(1'($urandom_range(0, 1)), $urandom, 32'd0);
                    2: issue(ffca_pkg::ACT_FREE, $urandom_range(0, sb.region[31:0] - 1),
                             $urandom_range(1, unit));
                    default: issue(ffca_pkg::ACT_FREE,
                                   $urandom_range(sb.region[31:0], 32'hFFFF_FFFF),
                                   $urandom_range(1, unit));
                endcase
            end
            if ($urandom_range(0, 29) == 0)
                quiet = ~quiet;
        end
    endtask

    initial
    begin
        sb = new();
        sb.reset_state();
        cycles = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(ffca_pkg::ACT_ALLOC, 32'd0, 32'd0);
        issue(ffca_pkg::ACT_ALLOC, 32'hFFFF_FFFF, 32'd1);
        issue(ffca_pkg::ACT_ALLOC, 32'd0, 32'hFFFF_FFFF);
        issue(ffca_pkg::ACT_ALLOC, 32'd0, 32'h0100_0000);
        issue(ffca_pkg::ACT_FREE, 32'hFFFF_FFFF, 32'd1);
        issue(ffca_pkg::ACT_FREE, 32'd0, 32'd0);
        issue(ffca_pkg::ACT_FREE, 32'h0000_8000, 32'hFFFF_FFFF);
        issue(ffca_pkg::ACT_FREE, 32'd0, 32'd1);
        issue(ffca_pkg::ACT_ALLOC, 32'd0, 32'h0100_0000);
        issue(ffca_pkg::ACT_ALLOC, 32'd0, 32'd1);
        issue(ffca_pkg::ACT_FREE, 32'h0000_2000, 32'h1000);
        issue(ffca_pkg::ACT_FREE, 32'd0, 32'h1000);
        issue(ffca_pkg::ACT_FREE, 32'h0000_1000, 32'h1000);
        issue(ffca_pkg::ACT_FREE, 32'h0000_3000, 32'h00FF_D000);
        issue(ffca_pkg::ACT_ALLOC, 32'd0, 32'h0000_2001);
        issue(ffca_pkg::ACT_FREE, 32'h00FF_FFFF, 32'd1);
        issue(ffca_pkg::ACT_FREE, 32'd0, 32'h0000_3000);
        live_off.delete();
        live_size.delete();
        unit = 32'h0004_0000;
        mixed(60);

        reg_write(ffca_pkg::REG_ALIGN_LOG2, 32'd0);
        reg_write(ffca_pkg::REG_REGION_SIZE, 32'd4096);
        for (int i = 0; i < 140; i++)
            issue(ffca_pkg::ACT_ALLOC, $urandom, $urandom_range(1, 3));
        for (int i = 0; i < 140; i += 2)
            issue(ffca_pkg::ACT_FREE, live_off[i], live_size[i]);
        live_off.delete();
        live_size.delete();
        unit = 32'd40;
        mixed(50);

        quiet = 1'b1;
        reg_write(ffca_pkg::REG_ALIGN_LOG2, 32'd31);
        reg_write(ffca_pkg::REG_REGION_SIZE, 32'hFFFF_FFFF);
        unit = 32'hFFFF_FFFF;
        mixed(60);

        quiet = 1'b0;
        reg_write(ffca_pkg::REG_ALIGN_LOG2, 32'd0);
        reg_write(ffca_pkg::REG_REGION_SIZE, 32'd1);
        unit = 32'd2;
        mixed(50);

        reg_write(ffca_pkg::REG_ALIGN_LOG2, 32'd5);
        reg_write(ffca_pkg::REG_REGION_SIZE, 32'd100000);
        unit = 32'd3000;
        mixed(80);

        reg_write(ffca_pkg::REG_REGION_SIZE, 32'h00AB_CDEF);
        reg_write(ffca_pkg::REG_ALIGN_LOG2, 32'd12);
        unit = 32'h0002_0000;
        mixed(60);

        drain();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ first_fit_coalescing_allocator.f @@
src/ffca_pkg.sv
src/ffca_mem.sv
src/ffca_cfg.sv
src/first_fit_coalescing_allocator.sv
tb/tb_top.sv
